/* design/utf8cp_pkg.sv */
`default_nettype none
package utf8cp_pkg;

	localparam int CNT_W     = 32;
	localparam int IDX_W     = 33;
	localparam int PHASE_W   = 6;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 32;
	localparam int Q_DEPTH   = 4;

	localparam int unsigned     DEF_GRANULARITY      = 64;
	localparam logic [15:0]     DEF_SHORT_ENTRY_LAST = 16'd255;
	localparam logic [31:0]     DEF_MID_ENTRY_LAST   = 32'd65535;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHUNK_PHASE    = 3'd0,
		CFG_BYTE_LIMIT     = 3'd1,
		CFG_CHAR_OFFSET    = 3'd2,
		CFG_START_INDEX    = 3'd3,
		CFG_ENTRY_CAPACITY = 3'd4
	} cfg_idx_t;

	typedef enum logic {
		KIND_ENTRY  = 1'b0,
		KIND_FINISH = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		EW_16 = 2'd0,
		EW_32 = 2'd1,
		EW_64 = 2'd2
	} ewidth_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_CAPACITY = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic [PHASE_W-1:0] chunk_phase;
		logic [CNT_W-1:0]   byte_limit;
		logic [CNT_W-1:0]   char_offset;
		logic [CNT_W-1:0]   start_index;
		logic [CNT_W-1:0]   entry_capacity;
	} cfg_t;

	typedef struct packed {
		kind_t              kind;
		logic [IDX_W-1:0]   index;
		logic [IDX_W-1:0]   value;
		ewidth_t            width;
		logic [CNT_W-1:0]   total_bytes;
		logic [CNT_W-1:0]   total_chars;
		status_t            status;
		logic               last;
	} result_t;

endpackage
`default_nettype wire

/* design/utf8cp_cfg.sv */
`default_nettype none
module utf8cp_cfg (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [utf8cp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [utf8cp_pkg::CFG_W-1:0]        cfg_data,
	output utf8cp_pkg::cfg_t                         cfg
);

	utf8cp_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (utf8cp_pkg::cfg_idx_t'(cfg_index))
				utf8cp_pkg::CFG_CHUNK_PHASE:
					cfg_q.chunk_phase <= cfg_data[utf8cp_pkg::PHASE_W-1:0];
				utf8cp_pkg::CFG_BYTE_LIMIT:     cfg_q.byte_limit     <= cfg_data;
				utf8cp_pkg::CFG_CHAR_OFFSET:    cfg_q.char_offset    <= cfg_data;
				utf8cp_pkg::CFG_START_INDEX:    cfg_q.start_index    <= cfg_data;
				utf8cp_pkg::CFG_ENTRY_CAPACITY: cfg_q.entry_capacity <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

/* design/utf8cp_core.sv */
`default_nettype none
module utf8cp_core #(
	parameter int unsigned  GRANULARITY      = utf8cp_pkg::DEF_GRANULARITY,
	parameter logic [15:0]  SHORT_ENTRY_LAST = utf8cp_pkg::DEF_SHORT_ENTRY_LAST,
	parameter logic [31:0]  MID_ENTRY_LAST   = utf8cp_pkg::DEF_MID_ENTRY_LAST
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire utf8cp_pkg::cfg_t    cfg,
	input  wire logic                accept,
	input  wire logic [7:0]          data_byte,
	input  wire logic                start_of_string,
	output logic [1:0]               push_n,
	output utf8cp_pkg::result_t      res0,
	output utf8cp_pkg::result_t      res1
);

	localparam int CW = $clog2(GRANULARITY + 1);
	localparam int NPH = 2 ** utf8cp_pkg::PHASE_W;
	localparam int W = utf8cp_pkg::CNT_W;
	localparam int IW = utf8cp_pkg::IDX_W;

	logic [CW-1:0] phase_mod [NPH];

	for (genvar p = 0; p < NPH; p++) begin : g_phase
		assign phase_mod[p] = CW'(p % GRANULARITY);
	end

	logic [W-1:0]  byte_count_q, char_count_q, entries_made_q;
	logic [CW-1:0] chunk_fill_q, chunk_limit_q;
	logic          run_active_q;

	logic [W-1:0]  bc, cc, em, bc_inc, cc_inc;
	logic [CW-1:0] fill, lim, fill_inc, first_len;
	logic          active, limit_hit, due, cap_full;
	logic [IW-1:0] idx, sum;
	logic [W-1:0]  nx_bc, nx_cc, nx_em;
	logic [CW-1:0] nx_fill, nx_lim;
	logic          nx_active;
	logic [1:0]    n;
	utf8cp_pkg::result_t r0, r1, ent;

	function automatic utf8cp_pkg::result_t finish(input logic [W-1:0] bytes,
			input logic [W-1:0] chars, input utf8cp_pkg::status_t st);
		utf8cp_pkg::result_t r;
		r = '0;
		r.kind        = utf8cp_pkg::KIND_FINISH;
		r.total_bytes = bytes;
		r.total_chars = chars;
		r.status      = st;
		r.last        = 1'b1;
		return r;
	endfunction

	assign first_len = CW'(GRANULARITY) - phase_mod[cfg.chunk_phase];

	always_comb begin
		// a start byte sees the cleared counters
		bc     = start_of_string ? '0 : byte_count_q;
		cc     = start_of_string ? '0 : char_count_q;
		em     = start_of_string ? '0 : entries_made_q;
		fill   = start_of_string ? '0 : chunk_fill_q;
		lim    = start_of_string ? first_len : chunk_limit_q;
		active = start_of_string | run_active_q;

		bc_inc    = bc + W'(1);
		cc_inc    = cc + W'(data_byte[7:6] != 2'b10);
		fill_inc  = fill + CW'(1);
		limit_hit = (cfg.byte_limit != '0) && (bc_inc == cfg.byte_limit);
		due       = (fill_inc >= lim) || limit_hit;
		cap_full  = (cfg.start_index != '0) && (em == cfg.entry_capacity);

		idx = {1'b0, cfg.start_index} + {1'b0, em};
		sum = {1'b0, cc_inc} + {1'b0, cfg.char_offset};

		ent       = '0;
		ent.kind  = utf8cp_pkg::KIND_ENTRY;
		ent.index = idx;
		ent.last  = ~limit_hit;
		if (idx <= IW'(SHORT_ENTRY_LAST)) begin
			ent.width = utf8cp_pkg::EW_16;
			ent.value = {{(IW-16){1'b0}}, sum[15:0]};
		end else if (idx <= IW'(MID_ENTRY_LAST)) begin
			ent.width = utf8cp_pkg::EW_32;
			ent.value = {1'b0, sum[W-1:0]};
		end else begin
			ent.width = utf8cp_pkg::EW_64;
			ent.value = sum;
		end

		n         = 2'd0;
		r0        = '0;
		r1        = '0;
		nx_bc     = bc;
		nx_cc     = cc;
		nx_em     = em;
		nx_fill   = fill;
		nx_lim    = lim;
		nx_active = active;

		if (!active) begin
			nx_active = 1'b0;
		end else if (data_byte == 8'd0) begin
			n         = 2'd1;
			r0        = finish(bc, cc, utf8cp_pkg::ST_OK);
			nx_active = 1'b0;
		end else if (bc == '1) begin
			n         = 2'd1;
			r0        = finish(bc, cc, utf8cp_pkg::ST_OVERFLOW);
			nx_active = 1'b0;
		end else begin
			nx_bc   = bc_inc;
			nx_cc   = cc_inc;
			nx_fill = fill_inc;
			if (due && cap_full) begin
				n         = 2'd1;
				r0        = finish(bc_inc, cc_inc, utf8cp_pkg::ST_CAPACITY);
				nx_active = 1'b0;
			end else begin
				if (due) begin
					r0      = ent;
					nx_em   = em + W'(1);
					nx_fill = '0;
					nx_lim  = CW'(GRANULARITY);
				end
				if (limit_hit) begin
					// limit always makes an entry first, so the finish goes second
					n         = 2'd2;
					r1        = finish(bc_inc, cc_inc, utf8cp_pkg::ST_OK);
					nx_active = 1'b0;
				end else if (due) begin
					n = 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= '0;
			char_count_q   <= '0;
			entries_made_q <= '0;
			chunk_fill_q   <= '0;
			chunk_limit_q  <= CW'(GRANULARITY);
			run_active_q   <= 1'b0;
		end else if (accept) begin
			byte_count_q   <= nx_bc;
			char_count_q   <= nx_cc;
			entries_made_q <= nx_em;
			chunk_fill_q   <= nx_fill;
			chunk_limit_q  <= nx_lim;
			run_active_q   <= nx_active;
		end
	end

	assign push_n = accept ? n : 2'd0;
	assign res0   = r0;
	assign res1   = r1;

	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !start_of_string && !run_active_q |-> push_n == 2'd0)
		else $error("byte outside a run produced a result");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push_n == 2'd2 |-> res0.kind == utf8cp_pkg::KIND_ENTRY
			&& res1.kind == utf8cp_pkg::KIND_FINISH && !res0.last)
		else $error("two results must be an entry followed by the finish");

	a_finish_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n == 2'd2) || (push_n == 2'd1 && res0.kind == utf8cp_pkg::KIND_FINISH)
		|=> !run_active_q)
		else $error("run still active after a finish result");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		run_active_q |-> chunk_fill_q < chunk_limit_q)
		else $error("chunk fill reached its limit without an entry");

endmodule
`default_nettype wire

/* design/utf8cp_rq.sv */
`default_nettype none
module utf8cp_rq (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [1:0]           push_n,
	input  wire utf8cp_pkg::result_t  d0,
	input  wire utf8cp_pkg::result_t  d1,
	input  wire logic                 pop,
	output logic                      room,
	output logic                      not_empty,
	output utf8cp_pkg::result_t       head
);

	localparam int D  = utf8cp_pkg::Q_DEPTH;
	localparam int PW = $clog2(D);

	utf8cp_pkg::result_t mem [D];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   count_q;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem[wr_ptr_q] <= d0;
		end
		if (push_n == 2'd2) begin
			mem[wr_ptr_q + PW'(1)] <= d1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push_n);
			rd_ptr_q <= rd_ptr_q + PW'(pop);
			count_q  <= count_q + (PW+1)'(push_n) - (PW+1)'(pop);
		end
	end

	// room for the worst case of two results from one byte
	assign room      = count_q <= (PW+1)'(D - 2);
	assign not_empty = count_q != '0;
	assign head      = mem[rd_ptr_q];

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd0 |-> count_q <= (PW+1)'(D - 2))
		else $error("result queue written without room");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("result queue read while empty");

endmodule
`default_nettype wire

/* design/utf8_checkpoint_builder.sv */
// Scans a string one byte per transfer, counting bytes and UTF-8 characters and emitting a
// checkpoint entry at every chunk boundary plus a totals result when a NUL, the byte limit,
// a full entry capacity or a byte-count overflow ends the run. A byte is taken every cycle
// while in_ready is high; its results are written into a four-deep result queue. A byte can
// give up to two results (an entry and the totals when the limit falls on it); the queue
// drains one result per cycle while out_ready is high, and in_ready drops while fewer than
// two queue slots are free, so the sustained rate is one byte per cycle as long as results
// are taken as fast as they come. chunk_phase is sampled by the byte that starts a run. The
// user must write configuration only while the block is idle; the block does not enforce it.
`default_nettype none
module utf8_checkpoint_builder #(
	parameter int unsigned  GRANULARITY      = utf8cp_pkg::DEF_GRANULARITY,
	parameter logic [15:0]  SHORT_ENTRY_LAST = utf8cp_pkg::DEF_SHORT_ENTRY_LAST,
	parameter logic [31:0]  MID_ENTRY_LAST   = utf8cp_pkg::DEF_MID_ENTRY_LAST
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [utf8cp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [utf8cp_pkg::CFG_W-1:0]      cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [7:0]                        data_byte,
	input  wire logic                              start_of_string,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   result_kind,
	output logic [utf8cp_pkg::IDX_W-1:0]           entry_index,
	output logic [utf8cp_pkg::IDX_W-1:0]           entry_value,
	output logic [1:0]                             entry_width,
	output logic [utf8cp_pkg::CNT_W-1:0]           total_bytes,
	output logic [utf8cp_pkg::CNT_W-1:0]           total_chars,
	output logic [1:0]                             run_status,
	output logic                                   last_result
);

	utf8cp_pkg::cfg_t    cfg;
	utf8cp_pkg::result_t res0, res1, head;
	logic [1:0]          push_n;
	logic                accept, pop, room, not_empty;

	assign accept = in_valid & in_ready;
	assign pop    = out_valid & out_ready;

	utf8cp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	utf8cp_core #(
		.GRANULARITY      (GRANULARITY),
		.SHORT_ENTRY_LAST (SHORT_ENTRY_LAST),
		.MID_ENTRY_LAST   (MID_ENTRY_LAST)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.accept          (accept),
		.data_byte       (data_byte),
		.start_of_string (start_of_string),
		.push_n          (push_n),
		.res0            (res0),
		.res1            (res1)
	);

	utf8cp_rq u_rq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.d0        (res0),
		.d1        (res1),
		.pop       (pop),
		.room      (room),
		.not_empty (not_empty),
		.head      (head)
	);

	assign in_ready    = room;
	assign out_valid   = not_empty;
	assign result_kind = head.kind;
	assign entry_index = head.index;
	assign entry_value = head.value;
	assign entry_width = head.width;
	assign total_bytes = head.total_bytes;
	assign total_chars = head.total_chars;
	assign run_status  = head.status;
	assign last_result = head.last;

endmodule
`default_nettype wire
